// ----- rtl/core/id3u_pkg.sv -----
package id3u_pkg;

    typedef enum logic [1:0] {
        MODE_LATIN1,
        MODE_UTF16LE,
        MODE_UTF16BE,
        MODE_UTF8
    } text_mode_t;

    localparam logic [7:0] SEL_UTF16    = 8'h01;
    localparam logic [7:0] SEL_UTF16BE  = 8'h02;
    localparam logic [7:0] SEL_UTF8     = 8'h03;
    localparam logic [7:0] BOM_FF       = 8'hFF;
    localparam logic [7:0] BOM_FE       = 8'hFE;

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [10:0] SUPP_OFFSET   = 11'h040;

    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    localparam logic [12:0] CAP_RESET = 13'd256;
    localparam int          CAP_W     = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       end_of_text;
    } out_word_t;

    // up to two code points per input, each with its utf-8 length (0 = unused)
    typedef struct packed {
        logic [20:0] cp_a;
        logic [2:0]  len_a;
        logic [20:0] cp_b;
        logic [2:0]  len_b;
        logic        end_of_text;
    } cmd_t;

    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80) begin
            n = 3'd1;
        end
        else if (cp < 21'h800) begin
            n = 3'd2;
        end
        else if (cp < 21'h10000) begin
            n = 3'd3;
        end
        else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            3'd1: b = cp[7:0];
            3'd2:
            begin
                case (idx)
                    2'd0:    b = LEAD2 | 8'(cp[10:6]);
                    default: b = CONT_MARK | 8'(cp[5:0]);
                endcase
            end
            3'd3:
            begin
                case (idx)
                    2'd0:    b = LEAD3 | 8'(cp[15:12]);
                    2'd1:    b = CONT_MARK | 8'(cp[11:6]);
                    default: b = CONT_MARK | 8'(cp[5:0]);
                endcase
            end
            3'd4:
            begin
                case (idx)
                    2'd0:    b = LEAD4 | 8'(cp[20:18]);
                    2'd1:    b = CONT_MARK | 8'(cp[17:12]);
                    2'd2:    b = CONT_MARK | 8'(cp[11:6]);
                    default: b = CONT_MARK | 8'(cp[5:0]);
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/id3_text_to_utf8_top.sv -----
// an accepted byte passes the command queue, the back end's command register and its result register
// before its first result word shows; input side takes one byte per cycle while the 4-entry command queue has room
// output side moves one utf-8 word per cycle while the result is popped or the output register is empty;
// a byte giving n words holds the back end until its last word, and a bare end marker yields one word
// reset: async active low, clears text mode, holds, byte count and queue; capacity returns to 256
module id3_text_to_utf8_top #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  id3u_pkg::in_word_t  item,
    output logic                empty,
    input  logic                pop,
    output id3u_pkg::out_word_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [12:0]         cfg_data
);
    import id3u_pkg::*;

    logic [12:0] capacity_reg;
    logic        accept;
    logic        cmd_push;
    cmd_t        cmd;
    cmd_t        q_head;
    logic        q_valid;
    logic        q_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    id3u_front #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .capacity (capacity_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    id3u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    id3u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_valid),
        .head_pop   (q_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ----- rtl/core/id3u_front.sv -----
module id3u_front #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  id3u_pkg::in_word_t item,
    input  logic [12:0]       capacity,
    output logic              cmd_push,
    output id3u_pkg::cmd_t    cmd
);
    import id3u_pkg::*;

    localparam int MAXC_W = $clog2(MAX_CAPACITY + 1);
    localparam int CMP_W  = (MAXC_W > CAP_W + 1) ? MAXC_W : CAP_W + 1;

    text_mode_t  mode_reg, mode_next;
    logic        await_bom_reg, await_bom_next;
    logic [7:0]  held_reg, held_next;
    logic        have_held_reg, have_held_next;
    logic [9:0]  pend_reg, pend_next;
    logic        have_pend_reg, have_pend_next;
    logic [12:0] bw_reg, bw_next;

    logic [CMP_W-1:0] cap_eff;
    logic [12:0]      bw_mid;
    logic             room_bw, room_mid, room_pass;
    logic [15:0]      unit_c;
    logic             is_high, is_low;
    logic [20:0]      pend_cp, comb_cp;

    assign cap_eff   = (CMP_W'(capacity) < CMP_W'(MAX_CAPACITY)) ? CMP_W'(capacity)
                                                                  : CMP_W'(MAX_CAPACITY);
    assign bw_mid    = have_pend_reg ? (bw_reg + 13'd3) : bw_reg;
    assign room_bw   = (CMP_W'(bw_reg) + CMP_W'(4)) < cap_eff;
    assign room_mid  = (CMP_W'(bw_mid) + CMP_W'(4)) < cap_eff;
    assign room_pass = (CMP_W'(bw_reg) + CMP_W'(1)) < cap_eff;
    assign unit_c    = (mode_reg == MODE_UTF16BE) ? {held_reg, item.in_byte}
                                                  : {item.in_byte, held_reg};
    assign is_high   = unit_c[15:10] == SURR_HIGH_TAG;
    assign is_low    = unit_c[15:10] == SURR_LOW_TAG;
    assign pend_cp   = {5'b0, SURR_HIGH_TAG, pend_reg};
    assign comb_cp   = {11'(pend_reg) + SUPP_OFFSET, unit_c[9:0]};

    always_comb
    begin
        logic unit;
        mode_next      = mode_reg;
        await_bom_next = await_bom_reg;
        held_next      = held_reg;
        have_held_next = have_held_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        bw_next        = bw_reg;
        cmd            = '0;
        cmd_push       = 1'b0;
        unit           = 1'b0;
        if (accept)
        begin
            if (item.first_of_frame)
            begin
                await_bom_next = 1'b0;
                have_held_next = 1'b0;
                have_pend_next = 1'b0;
                if (item.in_byte == SEL_UTF16)
                begin
                    mode_next      = MODE_UTF16LE;
                    await_bom_next = 1'b1;
                end
                else if (item.in_byte == SEL_UTF16BE)
                begin
                    mode_next = MODE_UTF16BE;
                end
                else if (item.in_byte == SEL_UTF8)
                begin
                    mode_next = MODE_UTF8;
                end
                else
                begin
                    mode_next = MODE_LATIN1;
                end
            end
            else if (mode_reg == MODE_UTF8)
            begin
                if (room_pass)
                begin
                    cmd.cp_a  = 21'(item.in_byte);
                    cmd.len_a = 3'd1;
                end
            end
            else if (mode_reg == MODE_LATIN1)
            begin
                if (room_bw)
                begin
                    cmd.cp_a  = 21'(item.in_byte);
                    cmd.len_a = cp_len(21'(item.in_byte));
                end
            end
            else if (!have_held_reg)
            begin
                held_next      = item.in_byte;
                have_held_next = 1'b1;
            end
            else
            begin
                have_held_next = 1'b0;
                unit           = 1'b1;
                if (await_bom_reg)
                begin
                    await_bom_next = 1'b0;
                    if (held_reg == BOM_FF && item.in_byte == BOM_FE)
                    begin
                        mode_next = MODE_UTF16LE;
                        unit      = 1'b0;
                    end
                    else if (held_reg == BOM_FE && item.in_byte == BOM_FF)
                    begin
                        mode_next = MODE_UTF16BE;
                        unit      = 1'b0;
                    end
                end
                if (unit)
                begin
                    if (have_pend_reg && is_low)
                    begin
                        have_pend_next = 1'b0;
                        cmd.cp_a       = comb_cp;
                        cmd.len_a      = 3'd4;
                    end
                    else
                    begin
                        if (have_pend_reg)
                        begin
                            have_pend_next = 1'b0;
                            cmd.cp_a       = pend_cp;
                            cmd.len_a      = 3'd3;
                        end
                        if (room_mid && unit_c != 16'h0000)
                        begin
                            if (is_high && !item.last_of_frame)
                            begin
                                pend_next      = unit_c[9:0];
                                have_pend_next = 1'b1;
                            end
                            else if (cmd.len_a == 3'd0)
                            begin
                                cmd.cp_a  = 21'(unit_c);
                                cmd.len_a = cp_len(21'(unit_c));
                            end
                            else
                            begin
                                cmd.cp_b  = 21'(unit_c);
                                cmd.len_b = cp_len(21'(unit_c));
                            end
                        end
                    end
                end
            end
            if (item.last_of_frame)
            begin
                // unpaired high surrogate flushed at end of payload
                if (have_pend_next)
                begin
                    if (cmd.len_a == 3'd0)
                    begin
                        cmd.cp_a  = pend_cp;
                        cmd.len_a = 3'd3;
                    end
                    else
                    begin
                        cmd.cp_b  = pend_cp;
                        cmd.len_b = 3'd3;
                    end
                end
                await_bom_next = 1'b0;
                have_held_next = 1'b0;
                have_pend_next = 1'b0;
            end
            if (item.first_of_frame)
            begin
                bw_next = 13'd0;
            end
            else
            begin
                bw_next = bw_reg + 13'(cmd.len_a) + 13'(cmd.len_b);
            end
            cmd.end_of_text = item.last_of_frame;
            cmd_push = (cmd.len_a != 3'd0) || (cmd.len_b != 3'd0) || item.last_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LATIN1;
            await_bom_reg <= 1'b0;
            have_held_reg <= 1'b0;
            have_pend_reg <= 1'b0;
            bw_reg        <= 13'd0;
        end
        else
        begin
            mode_reg      <= mode_next;
            await_bom_reg <= await_bom_next;
            have_held_reg <= have_held_next;
            have_pend_reg <= have_pend_next;
            bw_reg        <= bw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        pend_reg <= pend_next;
    end

endmodule

// ----- rtl/core/id3u_queue.sv -----
module id3u_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  id3u_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output id3u_pkg::cmd_t head,
    output logic           head_valid
);
    import id3u_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full command queue");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("pop from empty command queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("command queue overflow");

endmodule

// ----- rtl/core/id3u_back.sv -----
module id3u_back (
    input  logic               clk,
    input  logic               rst_n,
    input  id3u_pkg::cmd_t     head,
    input  logic               head_valid,
    output logic               head_pop,
    output id3u_pkg::out_word_t result,
    output logic               empty,
    input  logic               pop
);
    import id3u_pkg::*;

    cmd_t      cmd_reg, cmd_next;
    logic      busy_reg, busy_next;
    logic [2:0] k_reg, k_next;
    out_word_t res_reg, res_next;
    logic      res_valid_reg, res_valid_next;

    logic [2:0] total, final_k;
    logic       adv, at_final;
    logic [7:0] cur_byte;

    assign total    = cmd_reg.len_a + cmd_reg.len_b;
    assign final_k  = (total == 3'd0) ? 3'd0 : total - 3'd1;
    assign at_final = k_reg == final_k;
    assign adv      = !res_valid_reg || pop;
    assign cur_byte = (k_reg < cmd_reg.len_a)
                    ? utf8_byte(cmd_reg.cp_a, cmd_reg.len_a, k_reg[1:0])
                    : utf8_byte(cmd_reg.cp_b, cmd_reg.len_b, 2'(k_reg - cmd_reg.len_a));
    assign head_pop = head_valid && (!busy_reg || (adv && at_final));
    assign result   = res_reg;
    assign empty    = !res_valid_reg;

    always_comb
    begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (adv)
        begin
            res_valid_next = busy_reg;
            if (busy_reg)
            begin
                res_next.out_byte    = (total == 3'd0) ? 8'h00 : cur_byte;
                res_next.byte_valid  = total != 3'd0;
                res_next.last_of_run = at_final;
                res_next.end_of_text = cmd_reg.end_of_text;
                if (at_final)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
        end
        if (head_pop)
        begin
            cmd_next  = head;
            busy_next = 1'b1;
            k_next    = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    a_index_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> k_reg <= final_k) else $error("byte index past end of run");
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cmd_reg.len_a <= 3'd4 && cmd_reg.len_b <= 3'd4 && total <= 3'd6))
        else $error("command expands past six bytes");
    a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.byte_valid) |-> (res_reg.last_of_run && res_reg.end_of_text))
        else $error("end marker inside a run");
    a_marker_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && total == 3'd0) |-> cmd_reg.end_of_text)
        else $error("empty command without end of text");

endmodule
